FILE: hdl/bta_pkg.sv
package bta_pkg;

   // byte span of up to 65536 blocks of up to 65536 bytes needs one bit past 32
   localparam int SPAN_W = 33;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NOMEM   = 2'd1;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

   localparam logic REG_HEAP_BASE     = 1'b0;
   localparam logic REG_BLOCKS_IN_USE = 1'b1;

   localparam int BIU_W = 11;
   localparam logic [BIU_W-1:0] BIU_RESET = 11'd1024;

   typedef struct packed {
      logic has_next;
      logic first;
      logic taken;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOCATE,
      ST_SCAN,
      ST_MARK,
      ST_FREE,
      ST_PUSH
   } state_type;

endpackage

FILE: hdl/bta_req_if.sv
interface bta_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [31:0] size_bytes;
   logic [31:0] address;

   modport source (output valid, output cmd, output size_bytes, output address, input ready);
   modport sink (input valid, input cmd, input size_bytes, input address, output ready);
endinterface

FILE: hdl/bta_rsp_if.sv
interface bta_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_address;
   logic [1:0]  status;

   modport source (output valid, output result_address, output status, input ready);
   modport sink (input valid, input result_address, input status, output ready);
endinterface

FILE: hdl/block_table_heap_allocator_core.sv
// channel   dir  handshake       payload
// req_chan  in   valid / ready   cmd, size_bytes, address
// rsp_chan  out  valid / ready   result_address, status
// apb       in   psel, penable   paddr (0 heap_base, 4 blocks_in_use), pwdata, prdata
//
// one item at a time, taken in the idle state; the table memory has one read and one
// write port, so every walk goes one entry per cycle. an allocate scans entries up to
// the end of the first fitting run, then marks each block of that run; a free steps
// over entries to reach its block, then clears the entries of its run. a zero size,
// an empty heap or a free below the base goes straight from idle to the result.
// after reset a clearing pass writes all NUM_BLOCKS entries, one per cycle, before
// req_chan.ready rises; register writes are taken at any time.
// a finished result waits in the output register while the next item is accepted.
module block_table_heap_allocator_core #(
   parameter int NUM_BLOCKS  = 1024,
   parameter int BLOCK_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   bta_req_if.sink     req_chan,
   bta_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CW = $clog2(NUM_BLOCKS + 1);
   localparam int CMP_W = (CW > bta_pkg::BIU_W) ? CW : bta_pkg::BIU_W;
   localparam logic [bta_pkg::SPAN_W-1:0] BLK_SPAN = bta_pkg::SPAN_W'(BLOCK_BYTES);

   // table storage
   bta_pkg::entry_type mem [NUM_BLOCKS];
   bta_pkg::entry_type rd_data_ff;
   logic [IW-1:0]      rd_addr;
   logic               mem_we;
   logic [IW-1:0]      mem_waddr;
   bta_pkg::entry_type mem_wdata;

   bta_pkg::state_type state_ff, state_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [IW-1:0]      start_ff, start_in;
   logic [CW-1:0]      run_ff, run_in;
   logic [CW-1:0]      need_ff, need_in;
   logic [31:0]        target_ff, target_in;
   logic [bta_pkg::SPAN_W-1:0] span_ff, span_in;
   logic [31:0]        res_addr_ff, res_addr_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_addr_ff, rsp_addr_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic [31:0]               heap_base_ff;
   logic [bta_pkg::BIU_W-1:0] blocks_in_use_ff;

   logic [CMP_W-1:0]          biu_ext;
   logic [CW-1:0]             total;
   logic [bta_pkg::SPAN_W-1:0] target_ext;
   logic [CW-1:0]             idx_next_cnt;
   logic [IW-1:0]             run_start;
   logic                      csr_wr;

   // effective table size
   assign biu_ext = CMP_W'(blocks_in_use_ff);
   assign total = (biu_ext > CMP_W'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : CW'(biu_ext);

   assign target_ext = bta_pkg::SPAN_W'(target_ff);
   assign idx_next_cnt = CW'(idx_ff) + CW'(1);
   assign run_start = (run_ff == '0) ? idx_ff : start_ff;

   // configuration port
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_comb begin
      unique case (paddr[2])
         bta_pkg::REG_HEAP_BASE:     prdata = heap_base_ff;
         bta_pkg::REG_BLOCKS_IN_USE: prdata = 32'(blocks_in_use_ff);
         default:                    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= '0;
         blocks_in_use_ff <= bta_pkg::BIU_RESET;
      end else if (csr_wr) begin
         unique case (paddr[2])
            bta_pkg::REG_HEAP_BASE:     heap_base_ff <= pwdata;
            bta_pkg::REG_BLOCKS_IN_USE: blocks_in_use_ff <= pwdata[bta_pkg::BIU_W-1:0];
            default: ;
         endcase
      end
   end

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      start_in = start_ff;
      run_in = run_ff;
      need_in = need_ff;
      target_in = target_ff;
      span_in = span_ff;
      res_addr_in = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      rsp_addr_in = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         bta_pkg::ST_CLEAR: begin
            idx_in = idx_ff + IW'(1);
            if (idx_ff == IW'(NUM_BLOCKS - 1)) begin
               idx_in = '0;
               state_in = bta_pkg::ST_IDLE;
            end
         end
         bta_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               res_addr_in = '0;
               idx_in = '0;
               run_in = '0;
               span_in = BLK_SPAN;
               if (req_chan.cmd == bta_pkg::CMD_FREE) begin
                  target_in = req_chan.address - heap_base_ff;
                  if (req_chan.address < heap_base_ff || total == '0) begin
                     res_status_in = bta_pkg::STATUS_OUTSIDE;
                     state_in = bta_pkg::ST_PUSH;
                  end else begin
                     state_in = bta_pkg::ST_LOCATE;
                  end
               end else begin
                  target_in = req_chan.size_bytes;
                  if (req_chan.size_bytes == '0 || total == '0) begin
                     res_status_in = bta_pkg::STATUS_NOMEM;
                     state_in = bta_pkg::ST_PUSH;
                  end else begin
                     state_in = bta_pkg::ST_SCAN;
                  end
               end
            end
         end
         bta_pkg::ST_LOCATE: begin
            // span_ff is the byte offset just past block idx_ff
            if (target_ext < span_ff) begin
               state_in = bta_pkg::ST_FREE;
            end else if (idx_next_cnt == total) begin
               res_status_in = bta_pkg::STATUS_OUTSIDE;
               state_in = bta_pkg::ST_PUSH;
            end else begin
               idx_in = idx_ff + IW'(1);
               span_in = span_ff + BLK_SPAN;
            end
         end
         bta_pkg::ST_SCAN: begin
            // rd_data_ff holds the entry at idx_ff; span_ff is the run size if it is taken in
            if (rd_data_ff.taken) begin
               run_in = '0;
               span_in = BLK_SPAN;
               if (idx_next_cnt == total) begin
                  res_status_in = bta_pkg::STATUS_NOMEM;
                  state_in = bta_pkg::ST_PUSH;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end else if (span_ff >= target_ext) begin
               need_in = run_ff + CW'(1);
               start_in = run_start;
               idx_in = run_start;
               run_in = '0;
               state_in = bta_pkg::ST_MARK;
            end else begin
               start_in = run_start;
               run_in = run_ff + CW'(1);
               span_in = span_ff + BLK_SPAN;
               if (idx_next_cnt == total) begin
                  res_status_in = bta_pkg::STATUS_NOMEM;
                  state_in = bta_pkg::ST_PUSH;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         bta_pkg::ST_MARK: begin
            idx_in = idx_ff + IW'(1);
            run_in = run_ff + CW'(1);
            if (run_ff + CW'(1) == need_ff) begin
               res_addr_in = heap_base_ff + 32'(32'(start_ff) * 32'(BLOCK_BYTES));
               res_status_in = bta_pkg::STATUS_OK;
               state_in = bta_pkg::ST_PUSH;
            end
         end
         bta_pkg::ST_FREE: begin
            if (rd_data_ff.has_next && idx_next_cnt < total) begin
               idx_in = idx_ff + IW'(1);
            end else begin
               res_addr_in = '0;
               res_status_in = bta_pkg::STATUS_OK;
               state_in = bta_pkg::ST_PUSH;
            end
         end
         bta_pkg::ST_PUSH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in = res_addr_ff;
               rsp_status_in = res_status_ff;
               state_in = bta_pkg::ST_IDLE;
            end
         end
         default: state_in = bta_pkg::ST_IDLE;
      endcase
   end

   // memory control and handshake
   always_comb begin
      req_chan.ready = 1'b0;
      mem_we = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = '0;
      rd_addr = idx_ff;

      unique case (state_ff)
         bta_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
         end
         bta_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            rd_addr = '0;
         end
         bta_pkg::ST_SCAN: begin
            rd_addr = idx_ff + IW'(1);
         end
         bta_pkg::ST_MARK: begin
            mem_we = 1'b1;
            mem_wdata.taken = 1'b1;
            mem_wdata.first = (run_ff == '0);
            mem_wdata.has_next = (run_ff + CW'(1) < need_ff);
         end
         bta_pkg::ST_FREE: begin
            mem_we = 1'b1;
            rd_addr = idx_ff + IW'(1);
         end
         default: ;
      endcase
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.result_address = rsp_addr_ff;
   assign rsp_chan.status = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bta_pkg::ST_CLEAR;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      run_ff <= run_in;
      need_ff <= need_in;
      target_ff <= target_in;
      span_ff <= span_in;
      res_addr_ff <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule
